[rtl/u8sd_pkg.sv]
package u8sd_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        run_last;
    logic        text_end;
  } out_item_t;

  // up to two results from one input item, in order
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } step_out_t;

  localparam logic [20:0] BAD_POINT    = 21'h00FFFD;
  localparam logic [7:0]  LEAD2_MASK   = 8'hE0;
  localparam logic [7:0]  LEAD2_CODE   = 8'hC0;
  localparam logic [7:0]  LEAD3_MASK   = 8'hF0;
  localparam logic [7:0]  LEAD3_CODE   = 8'hE0;
  localparam logic [7:0]  LEAD4_MASK   = 8'hF8;
  localparam logic [7:0]  LEAD4_CODE   = 8'hF0;
  localparam logic [7:0]  CONT_MASK    = 8'hC0;
  localparam logic [7:0]  CONT_CODE    = 8'h80;
  localparam logic [2:0]  FOLLOW_MAX   = 3'd4;

  // code point of a closing group
  function automatic logic [20:0] close_point(input logic [7:0]  lead,
                                              input logic [2:0]  count,
                                              input logic [17:0] payload);
    logic [20:0] cp;
    cp = BAD_POINT;
    if ((lead & LEAD2_MASK) == LEAD2_CODE) begin
      if (count == 3'd1) cp = {10'd0, lead[4:0], payload[5:0]};
    end else if ((lead & LEAD3_MASK) == LEAD3_CODE) begin
      if (count == 3'd2) cp = {5'd0, lead[3:0], payload[11:0]};
    end else if ((lead & LEAD4_MASK) == LEAD4_CODE) begin
      if (count == 3'd3) cp = {lead[2:0], payload};
    end
    return cp;
  endfunction

endpackage

[rtl/u8sd_step.sv]
module u8sd_step
  import u8sd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_item_t  item,
  output step_out_t res
);

  logic        group_open;
  logic [7:0]  lead_value;
  logic [2:0]  follow_count;
  logic [17:0] payload_bits;

  logic        is_cont, is_ascii, joins, closes_old, new_open, fin_close;
  logic [2:0]  count_inc;
  logic [17:0] payload_join;
  logic [20:0] cp_old, cp_fin, cp_ascii, cp_a, cp_b;
  logic [1:0]  n;

  always_comb begin
    is_cont      = (item.text_byte & CONT_MASK) == CONT_CODE;
    is_ascii     = !item.text_byte[7];
    joins        = group_open && is_cont;
    closes_old   = group_open && !is_cont;
    new_open     = !is_ascii && !joins;
    fin_close    = item.final_byte && (joins || new_open);
    count_inc    = (follow_count < FOLLOW_MAX) ? follow_count + 3'd1 : follow_count;
    payload_join = {payload_bits[11:0], item.text_byte[5:0]};
    cp_old       = close_point(lead_value, follow_count, payload_bits);
    // a lead that is final closes with no continuations, always malformed
    cp_fin       = joins ? close_point(lead_value, count_inc, payload_join) : BAD_POINT;
    cp_ascii     = {13'd0, item.text_byte};
    n            = {1'b0, closes_old} + {1'b0, is_ascii} + {1'b0, fin_close};
    cp_b         = is_ascii ? cp_ascii : cp_fin;
    cp_a         = closes_old ? cp_old : cp_b;

    res.count             = n;
    res.first.code_point  = cp_a;
    res.first.run_last    = (n == 2'd1);
    res.first.text_end    = (n == 2'd1) && item.final_byte;
    res.second.code_point = cp_b;
    res.second.run_last   = 1'b1;
    res.second.text_end   = item.final_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_open   <= 1'b0;
      lead_value   <= '0;
      follow_count <= '0;
      payload_bits <= '0;
    end else if (fire) begin
      if (item.final_byte || (!joins && !new_open)) begin
        group_open   <= 1'b0;
        lead_value   <= '0;
        follow_count <= '0;
        payload_bits <= '0;
      end else if (joins) begin
        follow_count <= count_inc;
        payload_bits <= payload_join;
      end else begin
        group_open   <= 1'b1;
        lead_value   <= item.text_byte;
        follow_count <= '0;
        payload_bits <= '0;
      end
    end
  end

endmodule

[rtl/u8sd_result_fifo.sv]
module u8sd_result_fifo
  import u8sd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic [1:0] push_count,
  input  out_item_t push_a,
  input  out_item_t push_b,
  output logic      room_for_two,
  output logic      head_valid,
  output out_item_t head,
  input  logic      pop
);

  out_item_t   entries [4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  fill;
  logic        do_pop;

  assign do_pop       = pop && (fill != 3'd0);
  assign head_valid   = (fill != 3'd0);
  assign head         = entries[rd_ptr];
  assign room_for_two = (fill <= 3'd2);

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) entries[wr_ptr] <= push_a;
    if (push_count == 2'd2) entries[wr_ptr + 2'd1] <= push_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      if (do_pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {1'b0, push_count} - {2'd0, do_pop};
    end
  end

endmodule

[rtl/utf8_stream_decoder_core.sv]
// utf8 stream decoder
// in channel: one text byte per item (in_data.text_byte), final_byte set on the
//   last byte of a text; in_valid / in_ready handshake
// out channel: decoded code points (out_data), run_last on the last result that
//   an input item causes, text_end on the final result of a text
// one input item gives zero, one or two results; a closing malformed group
//   gives U+FFFD
// path: an item is held in the input register, then its results are written
//   into the result queue and offered from there; the item waits in the input
//   register while the queue lacks room for two
// throughput: one item per cycle while results are drained as fast as they
//   come; an item giving two results needs the output port twice, so the
//   output port (one result per cycle) sets the sustained rate
// reset: rst (synchronous) clears the group state, the input register and the
//   four-entry result queue; no clearing pass
// stall: when out_ready is low the queue fills; the input register only hands
//   its item on while the queue has room for two, and in_ready drops once the
//   input register is held
module utf8_stream_decoder_core
  import u8sd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // input register
  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_fire;
  logic      room_for_two;
  step_out_t step_res;
  logic [1:0] push_count;

  // item leaves the input register when two queue slots are free
  assign s1_fire    = s1_valid && room_for_two;
  assign in_ready   = !s1_valid || s1_fire;
  assign push_count = s1_fire ? step_res.count : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_item <= in_data;
  end

  // group tracking and close decode
  u8sd_step u_step (
    .clk  (clk),
    .rst  (rst),
    .fire (s1_fire),
    .item (s1_item),
    .res  (step_res)
  );

  // result queue, two writes and one read per cycle
  u8sd_result_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push_count   (push_count),
    .push_a       (step_res.first),
    .push_b       (step_res.second),
    .room_for_two (room_for_two),
    .head_valid   (out_valid),
    .head         (out_data),
    .pop          (out_ready)
  );

endmodule

[test/testbench.sv]
module testbench
  import u8sd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // directed stimulus: one byte per row, with the results written out where
  // they are obvious; n_typed of zero means the row is checked by the decoder
  // model below
  typedef struct packed {
    logic [7:0]  text_byte;
    logic        final_byte;
    logic [1:0]  n_typed;
    logic [20:0] point0;
    logic [20:0] point1;
  } probe_row_t;

  localparam int NUM_PROBES  = 24;
  localparam int NUM_BYTES   = 1750;
  // no idling on either side once this many bytes have gone in
  localparam int QUIET_AFTER = 1500;
  // the receiver stops for this long once, after HOLD_AT bytes
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 64;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // stimulus controls
  logic idle_on = 1'b1;
  logic long_hold = 1'b0;

  // decoder model state
  logic        grp_open;
  logic [7:0]  grp_lead;
  logic [2:0]  grp_follow;
  logic [17:0] grp_bits;

  // code points still due from the block, oldest first
  out_item_t pending_points[$];

  int n_errors = 0;
  int n_bytes = 0;
  int n_texts = 0;
  int n_results = 0;
  int n_bad_points = 0;
  int rx_burst = 0;

  always #2 clk = ~clk;

  utf8_stream_decoder_core DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    n_errors++;
  endtask

  function automatic void clear_group();
    grp_open   = 1'b0;
    grp_lead   = 8'h00;
    grp_follow = 3'd0;
    grp_bits   = 18'd0;
  endfunction

  // point given by the open group when it closes
  function automatic logic [20:0] group_point();
    logic [20:0] cp;
    cp = BAD_POINT;
    if (grp_lead[7:5] == 3'b110) begin
      if (grp_follow == 3'd1) cp = {10'd0, grp_lead[4:0], grp_bits[5:0]};
    end else if (grp_lead[7:4] == 4'b1110) begin
      if (grp_follow == 3'd2) cp = {5'd0, grp_lead[3:0], grp_bits[11:0]};
    end else if (grp_lead[7:3] == 5'b11110) begin
      if (grp_follow == 3'd3) cp = {grp_lead[2:0], grp_bits};
    end
    return cp;
  endfunction

  // advance the decoder model by one byte; queue its points when keep is set
  task automatic decode_byte(input in_item_t it, input bit keep);
    logic [20:0] pts [2];
    int          n;
    out_item_t   res;
    n = 0;
    if (grp_open && it.text_byte[7:6] == 2'b10) begin
      // continuation joins the group, count stops at four
      if (grp_follow < FOLLOW_MAX) grp_follow++;
      grp_bits = {grp_bits[11:0], it.text_byte[5:0]};
    end else begin
      if (grp_open) begin
        pts[n] = group_point();
        n++;
        clear_group();
      end
      if (!it.text_byte[7]) begin
        pts[n] = {13'd0, it.text_byte};
        n++;
      end else begin
        // any other byte, stray continuations too, leads a new group
        grp_open   = 1'b1;
        grp_lead   = it.text_byte;
        grp_follow = 3'd0;
        grp_bits   = 18'd0;
      end
    end
    if (it.final_byte && grp_open && n < 2) begin
      pts[n] = group_point();
      n++;
    end
    if (it.final_byte) clear_group();
    if (keep) begin
      for (int k = 0; k < n; k++) begin
        res.code_point = pts[k];
        res.run_last   = (k == n - 1);
        res.text_end   = (k == n - 1) && it.final_byte;
        pending_points.push_back(res);
      end
    end
  endtask

  // offer one byte and hold it until the block takes it
  task automatic send_item(input in_item_t it, input bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_bytes++;
  endtask

  // one text: mostly well-formed characters with random content, some
  // truncated or over-long groups and some raw noise bytes
  task automatic send_text();
    logic [7:0] bytes [$];
    int         n_chars;
    int         kind;
    int         len;
    in_item_t   it;
    n_chars = $urandom_range(1, 12);
    repeat (n_chars) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        bytes.push_back(8'($urandom_range(0, 127)));
      end else if (kind < 88) begin
        len = (kind < 60) ? 2 : ((kind < 74) ? 3 : 4);
        case (len)
          2:       bytes.push_back({3'b110, 5'($urandom)});
          3:       bytes.push_back({4'b1110, 4'($urandom)});
          default: bytes.push_back({5'b11110, 3'($urandom)});
        endcase
        // broken groups: cut short, or too many continuations
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(1, len - 1);
          1:       len = len + $urandom_range(1, 2);
          default: ;
        endcase
        repeat (len - 1) bytes.push_back({2'b10, 6'($urandom)});
      end else begin
        bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    for (int k = 0; k < bytes.size(); k++) begin
      it.text_byte  = bytes[k];
      it.final_byte = (k == bytes.size() - 1);
      decode_byte(it, 1'b1);
      send_item(it, idle_on);
    end
    n_texts++;
  endtask

  function automatic probe_row_t probe_row(input int i);
    probe_row_t r;
    case (i)
      // plain ascii at both ends of its range
      0:  r = '{8'h00, 1'b0, 2'd1, 21'h000000, 21'h0};
      1:  r = '{8'h7F, 1'b1, 2'd1, 21'h00007F, 21'h0};
      // two-byte group closed by ascii: two results from one byte
      2:  r = '{8'hC3, 1'b0, 2'd0, 21'h0, 21'h0};
      3:  r = '{8'hA9, 1'b0, 2'd0, 21'h0, 21'h0};
      4:  r = '{8'h41, 1'b0, 2'd0, 21'h0, 21'h0};
      // three-byte group closed by the final byte
      5:  r = '{8'hE2, 1'b0, 2'd0, 21'h0, 21'h0};
      6:  r = '{8'h82, 1'b0, 2'd0, 21'h0, 21'h0};
      7:  r = '{8'hAC, 1'b1, 2'd0, 21'h0, 21'h0};
      // four-byte group, then final ascii
      8:  r = '{8'hF0, 1'b0, 2'd0, 21'h0, 21'h0};
      9:  r = '{8'h9F, 1'b0, 2'd0, 21'h0, 21'h0};
      10: r = '{8'h98, 1'b0, 2'd0, 21'h0, 21'h0};
      11: r = '{8'h80, 1'b0, 2'd0, 21'h0, 21'h0};
      12: r = '{8'h20, 1'b1, 2'd0, 21'h0, 21'h0};
      // stray continuation as the final byte
      13: r = '{8'h80, 1'b1, 2'd1, 21'h00FFFD, 21'h0};
      // lead byte that is final
      14: r = '{8'hFF, 1'b1, 2'd1, 21'h00FFFD, 21'h0};
      // long group, the count reaches its limit of four
      15: r = '{8'hF4, 1'b0, 2'd0, 21'h0, 21'h0};
      16: r = '{8'hBF, 1'b0, 2'd0, 21'h0, 21'h0};
      17: r = '{8'hBF, 1'b0, 2'd0, 21'h0, 21'h0};
      18: r = '{8'hBF, 1'b0, 2'd0, 21'h0, 21'h0};
      19: r = '{8'hBF, 1'b0, 2'd0, 21'h0, 21'h0};
      // a new lead closes the long group and opens an empty one
      20: r = '{8'hC0, 1'b0, 2'd1, 21'h00FFFD, 21'h0};
      // final ascii closes the empty group first
      21: r = '{8'h7F, 1'b1, 2'd2, 21'h00FFFD, 21'h00007F};
      // highest two-byte point
      22: r = '{8'hDF, 1'b0, 2'd0, 21'h0, 21'h0};
      23: r = '{8'hBF, 1'b1, 2'd0, 21'h0, 21'h0};
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic check_result(input out_item_t got);
    out_item_t want;
    n_results++;
    if (got.code_point == BAD_POINT) n_bad_points++;
    if (pending_points.size() == 0) begin
      report_mismatch($sformatf("point %h arrived with none due", got.code_point));
    end else begin
      want = pending_points.pop_front();
      if (got.code_point != want.code_point)
        report_mismatch($sformatf("code_point %h, want %h", got.code_point,
                                  want.code_point));
      if (got.run_last != want.run_last)
        report_mismatch($sformatf("run_last %b, want %b on point %h", got.run_last,
                                  want.run_last, want.code_point));
      if (got.text_end != want.text_end)
        report_mismatch($sformatf("text_end %b, want %b on point %h", got.text_end,
                                  want.text_end, want.code_point));
    end
  endtask

  // receiver: check each accepted point, then pick next cycle's ready
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_burst = 0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (rx_burst > 0) begin
        rx_burst--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rx_burst = $urandom_range(1, 4);
      end
      out_ready <= !long_hold && rx_burst == 0;
    end
  end

  // one long receiver hold-off so the result queue fills and in_ready drops
  initial begin : hold_off
    int held;
    wait (n_bytes >= HOLD_AT);
    @(posedge clk);
    long_hold <= 1'b1;
    for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
    long_hold <= 1'b0;
  end

  // watchdog
  initial begin : watchdog
    #1_000_000;
    $display("timeout with %0d points still due", pending_points.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    in_item_t   it;
    probe_row_t probe;
    out_item_t  res;
    clear_group();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part
    for (int i = 0; i < NUM_PROBES; i++) begin
      probe = probe_row(i);
      it.text_byte  = probe.text_byte;
      it.final_byte = probe.final_byte;
      // the model runs on every row to keep its state in step
      decode_byte(it, probe.n_typed == 2'd0);
      if (probe.n_typed != 2'd0) begin
        res.code_point = probe.point0;
        res.run_last   = (probe.n_typed == 2'd1);
        res.text_end   = (probe.n_typed == 2'd1) && probe.final_byte;
        pending_points.push_back(res);
      end
      if (probe.n_typed == 2'd2) begin
        res.code_point = probe.point1;
        res.run_last   = 1'b1;
        res.text_end   = probe.final_byte;
        pending_points.push_back(res);
      end
      send_item(it, 1'b1);
    end

    // random texts
    while (n_bytes < NUM_BYTES) begin
      if (n_bytes >= QUIET_AFTER) idle_on <= 1'b0;
      send_text();
    end
    in_valid <= 1'b0;

    // drain, then give a late extra point time to show up
    while (pending_points.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("decoded %0d bytes in %0d texts into %0d points, %0d of them U+FFFD",
             n_bytes, n_texts, n_results, n_bad_points);
    $display("random idling on both sides, one %0d-cycle receiver hold-off, quiet tail",
             HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/u8sd_pkg.sv
rtl/u8sd_step.sv
rtl/u8sd_result_fifo.sv
rtl/utf8_stream_decoder_core.sv
test/testbench.sv
